### rtl/core/qfma_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qfma_pkg
// Shared types, tables and arithmetic helpers for the quadratic-fit moment
// accumulator.
// ---------------------------------------------------------------------------
package qfma_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam logic [1:0] CSR_RESOLUTION  = 2'd1;
   localparam logic [1:0] CSR_CONSTRAINED = 2'd2;

   localparam logic [5:0] LAST_INDEX   = 6'd41;
   localparam logic [5:0] OBS_BASE     = 6'd36;
   localparam logic [3:0] LAST_MONO    = 4'd14;
   localparam logic [3:0] LAST_POWER   = 4'd3;
   localparam logic signed [63:0] ONE_Q16 = 64'sd65536;

   // Datapath operations, one per product
   typedef enum logic [2:0] {
      OP_POWX  = 3'd0,
      OP_POWY  = 3'd1,
      OP_MONO  = 3'd2,
      OP_NTERM = 3'd3,
      OP_OTERM = 3'd4
   } op_type;

   // Right shift applied to a product
   typedef enum logic [1:0] {
      SH_15 = 2'd0,
      SH_16 = 2'd1,
      SH_23 = 2'd2
   } shift_type;

   typedef struct packed {
      op_type           op;
      logic [3:0]       idx;
      logic [2:0]       obs_idx;
      logic             start;
      logic             load;
      logic             clear;
      logic [5:0]       emit_idx;
      logic signed [7:0] col_off;
      logic signed [7:0] row_off;
   } cmd_type;

   typedef struct packed {
      logic done;
   } status_type;

   // Exponents of x and y for the fifteen moment sums
   localparam logic [2:0] XEXP [15] = '{3'd4, 3'd2, 3'd3, 3'd3, 3'd2, 3'd2, 3'd0, 3'd1,
                                        3'd1, 3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd0};
   localparam logic [2:0] YEXP [15] = '{3'd0, 3'd2, 3'd1, 3'd0, 3'd1, 3'd0, 3'd4, 3'd3,
                                        3'd2, 3'd3, 3'd2, 3'd1, 3'd0, 3'd1, 3'd0};

   // Matrix element to moment sum
   localparam logic [3:0] MAT_MAP [36] = '{
      4'd0, 4'd1,  4'd2,  4'd3,  4'd4,  4'd5,
      4'd1, 4'd6,  4'd7,  4'd8,  4'd9,  4'd10,
      4'd2, 4'd7,  4'd1,  4'd4,  4'd8,  4'd11,
      4'd3, 4'd8,  4'd4,  4'd5,  4'd11, 4'd12,
      4'd4, 4'd9,  4'd8,  4'd11, 4'd10, 4'd13,
      4'd5, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14};

   // Monomial shared with an observation term
   function automatic logic is_obs(input logic [3:0] i);
      return (i == 4'd5) || (i >= 4'd10);
   endfunction

   function automatic logic [2:0] obs_slot(input logic [3:0] i);
      logic [3:0] d;
      d = i - 4'd9;
      return (i == 4'd5) ? 3'd0 : d[2:0];
   endfunction

   // Signed add with saturation to 64 bits
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

endpackage
`default_nettype wire

### rtl/core/qfma_req_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qfma_req_if
// Cell channel: one weight and elevation per transfer.
// ---------------------------------------------------------------------------
interface qfma_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        weight;
   logic signed [31:0] elevation;

   modport source (output valid, weight, elevation, input ready);
   modport sink   (input valid, weight, elevation, output ready);
endinterface
`default_nettype wire

### rtl/core/qfma_rsp_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qfma_rsp_if
// Result channel: one matrix or vector element per transfer.
// ---------------------------------------------------------------------------
interface qfma_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         element_index;
   logic signed [63:0] element_value;
   logic               last_element;

   modport source (output valid, element_index, element_value, last_element, input ready);
   modport sink   (input valid, element_index, element_value, last_element, output ready);
endinterface
`default_nettype wire

### rtl/core/quadratic_fit_moment_accumulator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// quadratic_fit_moment_accumulator
// Builds the least-squares normal equations of a quadratic surface fit over
// a square window of weighted elevation cells.
//
// Send the window's cells in raster order on req_bus, one transfer per cell.
// Each cell takes 44 products on one shared 33x33 multiplier (43 when the
// constant observation moment is held at zero), and a cell occupies the
// block until its last product is done; ready is low meanwhile.
// After the last cell of a window the 36 matrix elements (row-major) and the
// 6 observation moments appear on rsp_bus, one per cycle while the receiver
// takes them; last_element marks the final one. A stalled receiver holds the
// current element and no new cell is taken until all 42 have gone out, then
// the sums clear. Reset clears sums and counters and loads the registers
// with window 3, resolution 1.0 and the constant moment unconstrained.
// Write csr_ registers only between windows' cells while the block is idle.
// ---------------------------------------------------------------------------
module quadratic_fit_moment_accumulator #(
   parameter int MAX_WINDOW = 63
) (
   input  wire         clock,
   input  wire         reset,
   qfma_req_if.sink    req_bus,
   qfma_rsp_if.source  rsp_bus,
   input  wire         csr_we,
   input  wire [1:0]   csr_index,
   input  wire [31:0]  csr_wdata
);
   logic [5:0]           window_size_ff;
   logic [31:0]          resolution_ff;
   logic                 constrained_ff;
   qfma_pkg::cmd_type    cmd;
   qfma_pkg::status_type status;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= 6'd3;
         resolution_ff  <= 32'd65536;
         constrained_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            qfma_pkg::CSR_WINDOW_SIZE: window_size_ff <= csr_wdata[5:0];
            qfma_pkg::CSR_RESOLUTION:  resolution_ff  <= csr_wdata;
            qfma_pkg::CSR_CONSTRAINED: constrained_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   qfma_ctrl #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_index   (rsp_bus.element_index),
      .rsp_last    (rsp_bus.last_element),
      .window_size (window_size_ff),
      .constrained (constrained_ff),
      .status      (status),
      .cmd         (cmd)
   );

   qfma_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .weight        (req_bus.weight),
      .elevation     (req_bus.elevation),
      .resolution    (resolution_ff),
      .status        (status),
      .element_value (rsp_bus.element_value)
   );

`ifndef SYNTHESIS
   // Never take a cell while results are pending
   assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("cell accepted during result transfer");

   // The last element closes the window and frees the input
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && rsp_bus.last_element |=> req_bus.ready)
      else $error("input not free after last element");

   // A cell transfer starts work, so no result follows at once
   assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !rsp_bus.valid && !req_bus.ready)
      else $error("cell transfer did not start work");
`endif
endmodule
`default_nettype wire

### rtl/core/qfma_mul.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qfma_mul
// Shared 64x64 signed multiplier built from one 33x33 partial product per
// cycle; floors the product by a selectable shift and saturates to 64 bits.
// ---------------------------------------------------------------------------
module qfma_mul (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire signed [63:0]      op_a,
   input  wire signed [63:0]      op_b,
   input  qfma_pkg::shift_type    shift,
   output logic                   done,
   output logic signed [63:0]     result
);
   logic signed [63:0]  a_ff, b_ff;
   qfma_pkg::shift_type sh_ff;
   logic [2:0]          step_ff, step_in;
   logic signed [65:0]  pp_ff, pp_in;
   logic signed [127:0] acc_ff, acc_in;
   logic signed [63:0]  result_ff, result_in;
   logic                done_ff, done_in;
   logic signed [32:0]  mx, my;
   logic signed [127:0] pp_ext, shifted;

   // Pick the halves for the current partial product
   always_comb begin
      case (step_ff)
         3'd1:    begin mx = {1'b0, a_ff[31:0]};     my = {1'b0, b_ff[31:0]};     end
         3'd2:    begin mx = {1'b0, a_ff[31:0]};     my = {b_ff[63], b_ff[63:32]}; end
         3'd3:    begin mx = {a_ff[63], a_ff[63:32]}; my = {1'b0, b_ff[31:0]};     end
         default: begin mx = {a_ff[63], a_ff[63:32]}; my = {b_ff[63], b_ff[63:32]}; end
      endcase
      pp_in  = mx * my;
      pp_ext = {{62{pp_ff[65]}}, pp_ff};
   end

   // Floor shift and saturate
   always_comb begin
      case (sh_ff)
         qfma_pkg::SH_15: shifted = acc_ff >>> 15;
         qfma_pkg::SH_23: shifted = acc_ff >>> 23;
         default:         shifted = acc_ff >>> 16;
      endcase
      if (shifted[127:63] == {65{1'b0}} || shifted[127:63] == {65{1'b1}}) begin
         result_in = shifted[63:0];
      end else begin
         result_in = shifted[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
   end

   // Accumulate the aligned partial products
   always_comb begin
      acc_in  = acc_ff;
      step_in = step_ff;
      done_in = 1'b0;
      case (step_ff)
         3'd0:    step_in = start ? 3'd1 : 3'd0;
         3'd1:    begin acc_in = '0; step_in = 3'd2; end
         3'd2:    begin acc_in = acc_ff + pp_ext; step_in = 3'd3; end
         3'd3:    begin acc_in = acc_ff + (pp_ext <<< 32); step_in = 3'd4; end
         3'd4:    begin acc_in = acc_ff + (pp_ext <<< 32); step_in = 3'd5; end
         3'd5:    begin acc_in = acc_ff + (pp_ext <<< 64); step_in = 3'd6; end
         3'd6:    begin step_in = 3'd0; done_in = 1'b1; end
         default: step_in = 3'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      if (start && step_ff == 3'd0) begin
         a_ff  <= op_a;
         b_ff  <= op_b;
         sh_ff <= shift;
      end
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
      if (done_in) begin
         result_ff <= result_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;
endmodule
`default_nettype wire

### rtl/core/qfma_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qfma_datapath
// Coordinates, powers, monomial and moment sums around the shared multiplier.
// ---------------------------------------------------------------------------
module qfma_datapath (
   input  wire                     clock,
   input  wire                     reset,
   input  qfma_pkg::cmd_type       cmd,
   input  wire [15:0]              weight,
   input  wire signed [31:0]       elevation,
   input  wire [31:0]              resolution,
   output qfma_pkg::status_type    status,
   output logic signed [63:0]      element_value
);
   logic [15:0]        w_ff;
   logic signed [47:0] wz_ff;
   logic signed [40:0] x_ff, y_ff;
   logic signed [63:0] px_ff [4];
   logic signed [63:0] py_ff [4];
   logic signed [63:0] m_ff;
   logic signed [63:0] nsum_ff [15];
   logic signed [63:0] obs_ff [6];

   logic [2:0]          px_addr, py_addr, px_m1, py_m1;
   logic signed [63:0]  px_rd, py_rd, nsum_rd, obs_rd;
   logic signed [63:0]  op_a, op_b, mul_result;
   qfma_pkg::shift_type shift;
   logic                mul_done;

   // Read ports: one address per store
   always_comb begin
      px_addr = (cmd.op == qfma_pkg::OP_MONO) ? qfma_pkg::XEXP[cmd.idx] : cmd.idx[2:0];
      py_addr = (cmd.op == qfma_pkg::OP_MONO) ? qfma_pkg::YEXP[cmd.idx] : cmd.idx[2:0];
      px_m1   = px_addr - 3'd1;
      py_m1   = py_addr - 3'd1;
      px_rd   = (px_addr == 3'd0) ? qfma_pkg::ONE_Q16 : px_ff[px_m1[1:0]];
      py_rd   = (py_addr == 3'd0) ? qfma_pkg::ONE_Q16 : py_ff[py_m1[1:0]];
      nsum_rd = nsum_ff[cmd.idx];
      obs_rd  = (cmd.obs_idx < 3'd6) ? obs_ff[cmd.obs_idx] : '0;
   end

   // Operand select for the multiplier
   always_comb begin
      op_a  = m_ff;
      op_b  = {{48{1'b0}}, w_ff};
      shift = qfma_pkg::SH_16;
      case (cmd.op)
         qfma_pkg::OP_POWX: begin op_a = px_rd; op_b = {{23{x_ff[40]}}, x_ff}; end
         qfma_pkg::OP_POWY: begin op_a = py_rd; op_b = {{23{y_ff[40]}}, y_ff}; end
         qfma_pkg::OP_MONO: begin op_a = px_rd; op_b = py_rd; end
         qfma_pkg::OP_NTERM: shift = qfma_pkg::SH_15;
         qfma_pkg::OP_OTERM: begin
            op_b  = {{16{wz_ff[47]}}, wz_ff};
            shift = qfma_pkg::SH_23;
         end
         default: shift = qfma_pkg::SH_16;
      endcase
   end

   qfma_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start),
      .op_a   (op_a),
      .op_b   (op_b),
      .shift  (shift),
      .done   (mul_done),
      .result (mul_result)
   );

   // Latch the cell and its coordinates
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         w_ff  <= weight;
         wz_ff <= $signed({1'b0, weight}) * elevation;
         x_ff  <= cmd.col_off * $signed({1'b0, resolution});
         y_ff  <= cmd.row_off * $signed({1'b0, resolution});
      end
      if (mul_done) begin
         case (cmd.op)
            qfma_pkg::OP_POWX: px_ff[cmd.idx[1:0]] <= mul_result;
            qfma_pkg::OP_POWY: py_ff[cmd.idx[1:0]] <= mul_result;
            qfma_pkg::OP_MONO: m_ff <= mul_result;
            default: ;
         endcase
      end
   end

   // Accumulate moment sums; clear after the window is sent
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < 15; i++) nsum_ff[i] <= '0;
         for (int i = 0; i < 6; i++) obs_ff[i] <= '0;
      end else if (mul_done) begin
         if (cmd.op == qfma_pkg::OP_NTERM) begin
            nsum_ff[cmd.idx] <= qfma_pkg::sat_add(nsum_rd, mul_result);
         end
         if (cmd.op == qfma_pkg::OP_OTERM && cmd.obs_idx < 3'd6) begin
            obs_ff[cmd.obs_idx] <= qfma_pkg::sat_add(obs_rd, mul_result);
         end
      end
   end

   assign status.done   = mul_done;
   assign element_value = (cmd.emit_idx < qfma_pkg::OBS_BASE) ? nsum_rd : obs_rd;
endmodule
`default_nettype wire

### rtl/core/qfma_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// qfma_ctrl
// Sequencer: cell counters, product schedule and result emission.
// ---------------------------------------------------------------------------
module qfma_ctrl #(
   parameter int MAX_WINDOW = 63
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [5:0]             rsp_index,
   output logic                   rsp_last,
   input  wire [5:0]              window_size,
   input  wire                    constrained,
   input  qfma_pkg::status_type   status,
   output qfma_pkg::cmd_type      cmd
);
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_START = 4'b0010,
      S_WAIT  = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   qfma_pkg::op_type op_ff, op_in;
   logic [3:0]       idx_ff, idx_in;
   logic [5:0]       k_ff, k_in;
   logic [5:0]       col_ff, col_in, row_ff, row_in;
   logic [5:0]       size, col_nx, row_nx, k_obs;
   logic [4:0]       edge_off;
   logic             load, clear, advance;

   // Clamp the window size and find the centre
   always_comb begin
      if (window_size < 6'd3) begin
         size = 6'd3;
      end else if ({1'b0, window_size} > 7'(MAX_WINDOW)) begin
         size = 6'(MAX_WINDOW);
      end else begin
         size = window_size;
      end
      edge_off = 5'((size - 6'd1) >> 1);
      col_nx   = col_ff + 6'd1;
      row_nx   = row_ff + 6'd1;
      k_obs    = k_ff - qfma_pkg::OBS_BASE;
   end

   // Next state and schedule
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      idx_in   = idx_ff;
      k_in     = k_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      load     = 1'b0;
      clear    = 1'b0;
      advance  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               load     = 1'b1;
               op_in    = qfma_pkg::OP_POWX;
               idx_in   = 4'd0;
               state_in = S_START;
            end
         end
         S_START: state_in = S_WAIT;
         S_WAIT: begin
            if (status.done) begin
               state_in = S_START;
               case (op_ff)
                  qfma_pkg::OP_POWX: op_in = qfma_pkg::OP_POWY;
                  qfma_pkg::OP_POWY: begin
                     if (idx_ff < qfma_pkg::LAST_POWER) begin
                        op_in  = qfma_pkg::OP_POWX;
                        idx_in = idx_ff + 4'd1;
                     end else begin
                        op_in  = qfma_pkg::OP_MONO;
                        idx_in = 4'd0;
                     end
                  end
                  qfma_pkg::OP_MONO: op_in = qfma_pkg::OP_NTERM;
                  qfma_pkg::OP_NTERM: begin
                     if (qfma_pkg::is_obs(idx_ff) &&
                         !(idx_ff == qfma_pkg::LAST_MONO && constrained)) begin
                        op_in = qfma_pkg::OP_OTERM;
                     end else begin
                        advance = 1'b1;
                     end
                  end
                  default: advance = 1'b1;
               endcase
               if (advance) begin
                  if (idx_ff < qfma_pkg::LAST_MONO) begin
                     op_in  = qfma_pkg::OP_MONO;
                     idx_in = idx_ff + 4'd1;
                  end else begin
                     // Step the cell counters; end of window starts emission
                     state_in = S_IDLE;
                     col_in   = col_nx;
                     if (col_nx >= size) begin
                        col_in = 6'd0;
                        row_in = row_nx;
                        if (row_nx >= size) begin
                           row_in   = 6'd0;
                           k_in     = 6'd0;
                           state_in = S_EMIT;
                        end
                     end
                  end
               end
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               if (k_ff == qfma_pkg::LAST_INDEX) begin
                  clear    = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 6'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= qfma_pkg::OP_POWX;
         idx_ff   <= 4'd0;
         k_ff     <= 6'd0;
         col_ff   <= 6'd0;
         row_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         idx_ff   <= idx_in;
         k_ff     <= k_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   // Commands to the datapath
   always_comb begin
      cmd.op       = op_ff;
      cmd.start    = (state_ff == S_START);
      cmd.load     = load;
      cmd.clear    = clear;
      cmd.emit_idx = k_ff;
      cmd.col_off  = $signed({2'b00, col_ff}) - $signed({3'b000, edge_off});
      cmd.row_off  = $signed({2'b00, row_ff}) - $signed({3'b000, edge_off});
      if (state_ff == S_EMIT) begin
         cmd.idx     = (k_ff < qfma_pkg::OBS_BASE) ? qfma_pkg::MAT_MAP[k_ff] : 4'd0;
         cmd.obs_idx = k_obs[2:0];
      end else begin
         cmd.idx     = idx_ff;
         cmd.obs_idx = qfma_pkg::obs_slot(idx_ff);
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);
   assign rsp_index = k_ff;
   assign rsp_last  = (k_ff == qfma_pkg::LAST_INDEX);
endmodule
`default_nettype wire

### tb/quadratic_fit_moment_accumulator_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// quadratic_fit_moment_accumulator_test
// Sends windows of weighted elevation cells, predicts the 42 normal-equation
// elements of every window with its own fixed-point model, and compares each
// result transfer with the oldest predicted element. Covers register extremes,
// saturation, a mid-window size change, random windows under random idling
// and a long receiver hold-off that stalls the cell channel.
// ---------------------------------------------------------------------------
module quadratic_fit_moment_accumulator_test;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 800;
   localparam int HOLD_CYCLES    = 4000;

   localparam logic signed [127:0] WIDE_MAX = 128'sh7fff_ffff_ffff_ffff;
   localparam logic signed [127:0] WIDE_MIN = -WIDE_MAX - 128'sd1;

   typedef struct {
      logic [5:0]         index;
      logic signed [63:0] value;
      logic               last;
   } element_type;

   // Exponent and matrix tables of the moment sums
   localparam int X_POW [15] = '{4, 2, 3, 3, 2, 2, 0, 1, 1, 0, 0, 1, 1, 0, 0};
   localparam int Y_POW [15] = '{0, 2, 1, 0, 1, 0, 4, 3, 2, 3, 2, 1, 0, 1, 0};
   localparam int OBS_X [6]  = '{2, 0, 1, 1, 0, 0};
   localparam int OBS_Y [6]  = '{0, 2, 1, 0, 1, 0};
   localparam int SUM_OF_ELEMENT [36] = '{
      0, 1, 2, 3, 4, 5,
      1, 6, 7, 8, 9, 10,
      2, 7, 1, 4, 8, 11,
      3, 8, 4, 5, 11, 12,
      4, 9, 8, 11, 10, 13,
      5, 10, 11, 12, 13, 14};

   logic clock;
   logic reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   qfma_req_if req_bus ();
   qfma_rsp_if rsp_bus ();

   quadratic_fit_moment_accumulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted state and registers
   logic signed [63:0] moment_sums [15];
   logic signed [63:0] elevation_sums [6];
   logic [5:0]  row_pos;
   logic [5:0]  col_pos;
   logic [5:0]  size_reg;
   logic [31:0] resolution_reg;
   logic        constrained_reg;

   element_type pending_elements [$];
   int       error_count;
   int       cells_sent;
   int       send_idle_pct;
   int       recv_idle_pct;
   logic     hold_go;
   logic     hold_active;
   int       quiet_cycles;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Floor-shifted exact product, saturated to 64 bits
   function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int s);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] p;
      wa = a;
      wb = b;
      p = (wa * wb) >>> s;
      if (p > WIDE_MAX) return WIDE_MAX[63:0];
      if (p < WIDE_MIN) return WIDE_MIN[63:0];
      return p[63:0];
   endfunction

   function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   function automatic int effective_size();
      if (size_reg < 3) return 3;
      return int'(size_reg);
   endfunction

   function automatic void clear_moments();
      foreach (moment_sums[k]) moment_sums[k] = '0;
      foreach (elevation_sums[k]) elevation_sums[k] = '0;
   endfunction

   // Accumulate one cell; queue the 42 elements when the window closes
   function automatic void accumulate_cell(input logic [15:0] weight,
                                           input logic signed [31:0] elevation);
      int size;
      logic signed [63:0] edge_off;
      logic signed [63:0] w;
      logic signed [63:0] wz;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] px [5];
      logic signed [63:0] py [5];
      logic signed [63:0] m;
      element_type e;
      size = effective_size();
      edge_off = (size - 1) / 2;
      w = {48'd0, weight};
      wz = w * 64'(elevation);
      x = ($signed({58'd0, col_pos}) - edge_off) * $signed({32'd0, resolution_reg});
      y = ($signed({58'd0, row_pos}) - edge_off) * $signed({32'd0, resolution_reg});
      px[0] = 64'sd65536;
      py[0] = 64'sd65536;
      for (int k = 1; k < 5; k++) begin
         px[k] = scaled_product(px[k-1], x, 16);
         py[k] = scaled_product(py[k-1], y, 16);
      end
      for (int k = 0; k < 15; k++) begin
         m = scaled_product(px[X_POW[k]], py[Y_POW[k]], 16);
         moment_sums[k] = clamp_add(moment_sums[k], scaled_product(m, w, 15));
      end
      for (int k = 0; k < 6; k++) begin
         if (!(k == 5 && constrained_reg)) begin
            m = scaled_product(px[OBS_X[k]], py[OBS_Y[k]], 16);
            elevation_sums[k] = clamp_add(elevation_sums[k], scaled_product(m, wz, 23));
         end
      end
      // Advance raster position, wrapping counters at or past the size
      col_pos = col_pos + 6'd1;
      if (int'(col_pos) >= size) begin
         col_pos = '0;
         row_pos = row_pos + 6'd1;
         if (int'(row_pos) >= size) begin
            row_pos = '0;
            for (int k = 0; k < 42; k++) begin
               e.index = 6'(k);
               e.value = (k < 36) ? moment_sums[SUM_OF_ELEMENT[k]] : elevation_sums[k-36];
               e.last  = (6'(k) == qfma_pkg::LAST_INDEX);
               pending_elements.push_back(e);
            end
            clear_moments();
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Result checker
   always @(posedge clock) begin
      element_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_elements.size() == 0) begin
            report_mismatch("unexpected element", 64'(rsp_bus.element_index), 64'd0);
         end else begin
            e = pending_elements.pop_front();
            if (rsp_bus.element_index !== e.index)
               report_mismatch("element_index", 64'(rsp_bus.element_index), 64'(e.index));
            if (rsp_bus.element_value !== e.value)
               report_mismatch($sformatf("element_value[%0d]", e.index),
                               rsp_bus.element_value, e.value);
            if (rsp_bus.last_element !== e.last)
               report_mismatch("last_element", 64'(rsp_bus.last_element), 64'(e.last));
         end
      end
   end

   // Receiver readiness, with random idling and long hold-off
   always @(negedge clock) begin
      rsp_bus.ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      hold_active = 1'b0;
      forever begin
         wait (hold_go);
         hold_active = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active = 1'b0;
         wait (!hold_go);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic send_cell(input logic [15:0] weight, input logic signed [31:0] elevation);
      if (send_idle_pct > 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.weight    <= weight;
      req_bus.elevation <= elevation;
      do @(posedge clock); while (!req_bus.ready);
      accumulate_cell(weight, elevation);
      cells_sent++;
   endtask

   task automatic stop_cells();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // Drop valid, drain expectations, then let the block finish any cell
   task automatic settle();
      stop_cells();
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         qfma_pkg::CSR_WINDOW_SIZE: size_reg = value[5:0];
         qfma_pkg::CSR_RESOLUTION:  resolution_reg = value;
         qfma_pkg::CSR_CONSTRAINED: constrained_reg = value[0];
         default: ;
      endcase
   endtask

   task automatic send_random_cell();
      logic [15:0] w;
      logic [31:0] z;
      w = ($urandom_range(99) < 85) ? 16'($urandom_range(0, 32768)) : 16'($urandom);
      z = ($urandom_range(99) < 50) ? 32'($urandom_range(0, 4000) - 2000) : $urandom;
      send_cell(w, z);
   endtask

   task automatic send_random_window();
      int n;
      n = effective_size() * effective_size();
      repeat (n) send_random_cell();
   endtask

   // Reset defaults: window 3, resolution 1.0, with field extremes
   task automatic test_reset_defaults();
      send_cell(16'd0, 32'sh7fffffff);
      send_cell(16'd32768, 32'sh80000000);
      send_cell(16'hffff, 32'sh7fffffff);
      send_cell(16'hffff, 32'sh80000000);
      send_cell(16'd32768, -32'sd1);
      send_cell(16'd1, 32'sd0);
      send_cell(16'h5555, 32'sh55555555);
      send_cell(16'haaaa, 32'shaaaaaaaa);
      send_cell(16'd32768, 32'sd256);
      settle();
   endtask

   // Small size clamped to 3, largest resolution, constrained, saturation
   task automatic test_saturation();
      write_register(qfma_pkg::CSR_WINDOW_SIZE, 32'd0);
      write_register(qfma_pkg::CSR_RESOLUTION, 32'hffffffff);
      write_register(qfma_pkg::CSR_CONSTRAINED, 32'd1);
      repeat (9) send_cell(16'hffff, 32'sh7fffffff);
      settle();
      write_register(qfma_pkg::CSR_RESOLUTION, 32'd0);
      write_register(qfma_pkg::CSR_CONSTRAINED, 32'd0);
      repeat (9) send_cell(16'd32768, 32'sh80000000);
      settle();
   endtask

   // Size change in the middle of a window wraps the column counter
   task automatic test_size_change_mid_window();
      write_register(qfma_pkg::CSR_RESOLUTION, 32'd1);
      write_register(qfma_pkg::CSR_WINDOW_SIZE, 32'd63);
      repeat (4) send_random_cell();
      settle();
      write_register(qfma_pkg::CSR_WINDOW_SIZE, 32'd4);
      write_register(qfma_pkg::CSR_RESOLUTION, 32'd65536);
      while (!(row_pos == 0 && col_pos == 0)) send_random_cell();
      settle();
   endtask

   task automatic test_random_windows(input int sender_pct, input int receiver_pct,
                                      input int cell_count);
      int stop_at;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      stop_at = cells_sent + cell_count;
      while (cells_sent < stop_at) begin
         if ($urandom_range(99) < 40) begin
            settle();
            case ($urandom_range(0, 9))
               0: write_register(qfma_pkg::CSR_WINDOW_SIZE, 32'($urandom_range(0, 2)));
               1, 2: write_register(qfma_pkg::CSR_WINDOW_SIZE, 32'd4);
               3, 4: write_register(qfma_pkg::CSR_WINDOW_SIZE, 32'd5);
               default: write_register(qfma_pkg::CSR_WINDOW_SIZE, 32'd3);
            endcase
            case ($urandom_range(0, 5))
               0: write_register(qfma_pkg::CSR_RESOLUTION, 32'd0);
               1: write_register(qfma_pkg::CSR_RESOLUTION, 32'hffffffff);
               2: write_register(qfma_pkg::CSR_RESOLUTION, $urandom);
               default: write_register(qfma_pkg::CSR_RESOLUTION,
                                       32'($urandom_range(1, 32'h40000)));
            endcase
            write_register(qfma_pkg::CSR_CONSTRAINED, 32'($urandom_range(0, 1)));
         end
         send_random_window();
      end
      settle();
   endtask

   // Receiver holds off while cells keep coming, so the input stalls
   task automatic test_receiver_hold_off();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(qfma_pkg::CSR_WINDOW_SIZE, 32'd3);
      hold_go = 1'b1;
      repeat (18) send_random_cell();
      hold_go = 1'b0;
      settle();
   endtask

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.weight  = '0;
      req_bus.elevation = '0;
      rsp_bus.ready   = 1'b0;
      hold_go         = 1'b0;
      quiet_cycles    = 0;
      error_count     = 0;
      cells_sent      = 0;
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      size_reg        = 6'd3;
      resolution_reg  = 32'd65536;
      constrained_reg = 1'b0;
      row_pos         = '0;
      col_pos         = '0;
      clear_moments();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_saturation();
      test_size_change_mid_window();
      test_random_windows(19, 46, 90);
      test_random_windows(46, 19, 90);
      test_random_windows(0, 0, 90);
      test_receiver_hold_off();

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
